// ===== rtl/assert_macros.svh =====
// Assertion macros for the permutation rank block.
// No dependencies; taken in by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define PRCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define PRCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/prct_pkg.sv =====
// Shared types, constants and the all-present count function of the count tree.
// No dependencies.
`default_nettype none

package prct_pkg;

  localparam int LEAVES  = 1024;
  localparam int LOG2P   = $clog2(LEAVES);
  localparam int P       = 1 << LOG2P;
  localparam int ADDR_W  = LOG2P + 1;
  localparam int CNT_W   = $clog2(LEAVES + 1);
  localparam int DEPTH_W = $clog2(LOG2P + 1);
  localparam int TAG_W   = 6;
  localparam int TAG_MAX = (1 << TAG_W) - 1;
  localparam int VALUE_W = 11;
  localparam int DIGIT_W = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               final_element;
  } in_word_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               already_gone;
    logic               final_result;
  } out_word_t;

  // One tree node as stored: epoch tag plus the count itself.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic             sweeping;
    logic [TAG_W-1:0] epoch;
  } walk_stat_t;

  // Count a node holds with all values present: leaves of its subtree
  // that fall inside 1..LEAVES.
  function automatic logic [CNT_W-1:0] default_count(input logic [ADDR_W-1:0]  addr,
                                                      input logic [DEPTH_W-1:0] depth);
    logic [DEPTH_W-1:0] up;
    logic [ADDR_W:0]    first;
    logic [ADDR_W:0]    span;
    logic [ADDR_W:0]    left;
    up    = DEPTH_W'(LOG2P) - depth;
    first = ({1'b0, addr} << up) - (ADDR_W+1)'(P);
    span  = (ADDR_W+1)'(1) << up;
    left  = (ADDR_W+1)'(LEAVES) - first;
    if (first >= (ADDR_W+1)'(LEAVES)) begin
      return '0;
    end else if (left >= span) begin
      return CNT_W'(span);
    end else begin
      return CNT_W'(left);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/prct_tree_mem.sv =====
// Count tree storage: one write port, one read port, registered read data.
// Depends on prct_pkg.
`default_nettype none

module prct_tree_mem import prct_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem_r [0:(1 << ADDR_W)-1];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/prct_walk.sv =====
// Walk sequencer: leaf check, leaf-to-root read-modify-write, epoch and sweep.
// Depends on prct_pkg; drives prct_tree_mem.
`default_nettype none

module prct_walk import prct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       res_valid,
  input  logic       res_ready,
  output out_word_t  res_word,
  output mem_req_t   mem_req,
  input  entry_t     mem_rdata,
  output walk_stat_t stat
);

  typedef enum logic [5:0] {
    ST_SWEEP = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_ROOT  = 6'b010000,
    ST_DONE  = 6'b100000
  } walk_state_t;

  walk_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0]  sweep_r, sweep_nxt;
  logic [TAG_W-1:0]   epoch_r, epoch_nxt;
  logic [ADDR_W-1:0]  node_r, node_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic               in_range_r, in_range_nxt;
  logic               fin_r, fin_nxt;
  logic               gone_r, gone_nxt;

  logic [ADDR_W-1:0]  leaf_addr;
  logic [ADDR_W-1:0]  rd_node;
  logic [CNT_W-1:0]   rd_cnt;
  logic [ADDR_W-1:0]  parent;

  assign leaf_addr = ADDR_W'(P) + ADDR_W'(in_word.value) - ADDR_W'(1);
  // CHECK sees the leaf itself, WALK sees the sibling of the current node.
  assign rd_node   = (state_r == ST_CHECK) ? node_r : (node_r ^ ADDR_W'(1));
  // Stale epoch: node reads as its all-present value.
  assign rd_cnt    = (mem_rdata.tag == epoch_r) ? mem_rdata.cnt
                                                : default_count(rd_node, depth_r);
  assign parent    = node_r >> 1;

  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    epoch_nxt    = epoch_r;
    node_nxt     = node_r;
    depth_nxt    = depth_r;
    cur_nxt      = cur_r;
    acc_nxt      = acc_r;
    in_range_nxt = in_range_r;
    fin_nxt      = fin_r;
    gone_nxt     = gone_r;
    mem_req      = '0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = sweep_r;
        mem_req.wr_data = '0;
        sweep_nxt       = sweep_r + ADDR_W'(1);
        if (sweep_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = leaf_addr;
          node_nxt        = leaf_addr;
          depth_nxt       = DEPTH_W'(LOG2P);
          in_range_nxt    = (in_word.value != '0) && (32'(in_word.value) <= 32'(LEAVES));
          fin_nxt         = in_word.final_element;
          acc_nxt         = '0;
          state_nxt       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!in_range_r || rd_cnt == '0) begin
          gone_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          gone_nxt        = 1'b0;
          cur_nxt         = rd_cnt;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = node_r ^ ADDR_W'(1);
          state_nxt       = ST_WALK;
        end
      end
      ST_WALK: begin
        mem_req.wr_en       = 1'b1;
        mem_req.wr_addr     = node_r;
        mem_req.wr_data.tag = epoch_r;
        mem_req.wr_data.cnt = cur_r - CNT_W'(1);
        if (node_r[0]) begin
          acc_nxt = acc_r + rd_cnt;
        end
        // parent's old count is the sum of its two children
        cur_nxt   = cur_r + rd_cnt;
        node_nxt  = parent;
        depth_nxt = depth_r - DEPTH_W'(1);
        if (parent == ADDR_W'(1)) begin
          state_nxt = ST_ROOT;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = parent ^ ADDR_W'(1);
        end
      end
      ST_ROOT: begin
        mem_req.wr_en       = 1'b1;
        mem_req.wr_addr     = node_r;
        mem_req.wr_data.tag = epoch_r;
        mem_req.wr_data.cnt = cur_r - CNT_W'(1);
        state_nxt           = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
          if (fin_r) begin
            if (epoch_r == TAG_W'(TAG_MAX)) begin
              epoch_nxt = TAG_W'(1);
              sweep_nxt = '0;
              state_nxt = ST_SWEEP;
            end else begin
              epoch_nxt = epoch_r + TAG_W'(1);
            end
          end
        end
      end
      default: begin
        sweep_nxt = '0;
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      sweep_r <= '0;
      epoch_r <= TAG_W'(1);
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      epoch_r <= epoch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    depth_r    <= depth_nxt;
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    in_range_r <= in_range_nxt;
    fin_r      <= fin_nxt;
    gone_r     <= gone_nxt;
  end

  assign res_word.digit        = DIGIT_W'(acc_r);
  assign res_word.already_gone = gone_r;
  assign res_word.final_result = fin_r;

  assign stat.sweeping = (state_r == ST_SWEEP);
  assign stat.epoch    = epoch_r;

endmodule

`default_nettype wire

// ===== rtl/permutation_rank_count_tree_core.sv =====
// Top level of the permutation rank block: walk sequencer, tree memory, output register.
// Depends on prct_pkg, prct_tree_mem, prct_walk and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Permutation rank (Lehmer digit) core. Each input word carries one permutation
// element; the result word gives the number of still-present values below it and
// then removes it. A value already removed, or outside 1..LEAVES, comes back with
// already_gone set, digit 0, and no change to the tree. After a word marked
// final_element the tree is back to all values present. One word is in flight at
// a time. A present value goes through one read of the leaf, then one tree level
// per cycle, where each cycle reads the sibling and writes back the decremented
// path node over the single read and single write port of the tree memory, then
// the root write and the hand-off; a flagged value only has its leaf read. The
// result sits in an output register, so a stalled consumer only holds the core
// once a second result is ready. Restoring the tree after a final word is free:
// every stored node carries a 6-bit epoch tag and a node with a stale tag reads
// as its all-present count. The tags are renewed by a sweep of the whole memory
// that runs after reset and again after every 63rd final word; no word is
// accepted during a sweep.
module permutation_rank_count_tree_core import prct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  mem_req_t   mem_req;
  entry_t     mem_rdata;
  walk_stat_t stat;

  logic       res_valid;
  logic       res_ready;
  out_word_t  res_word;

  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  prct_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .stat      (stat)
  );

  // Reads never target the node written in the same cycle: within a walk the
  // reads are siblings and the writes are path nodes, and a new word's leaf
  // read only starts after the previous walk's root write.
  prct_tree_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  // Output register: refills whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_word_nxt = res_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `PRCT_ASSERT(a_no_rw_same_node, (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr), "tree read and write hit the same node")
  `PRCT_ASSERT(a_epoch_nonzero, stat.epoch != '0, "epoch tag zero collides with swept entries")
  `PRCT_ASSERT(a_no_accept_in_sweep, stat.sweeping |-> !in_ready, "word accepted during tag sweep")
  `PRCT_ASSERT(a_sweep_tag_zero, (stat.sweeping && mem_req.wr_en) |-> (mem_req.wr_data.tag == '0), "sweep wrote a live tag")

endmodule

`default_nettype wire
